@@ rtl/psv_pkg.sv @@
// Pie-slice vertex generator: shared constants, register indexes and CORDIC table.
// No dependencies; imported by the CORDIC cell, the top level and the bench.
package psv_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int RADIUS_BITS  = 20;
    localparam int TURN_BITS    = 16;
    localparam int ANG_W        = 32;
    localparam int PH_SHIFT     = ANG_W - TURN_BITS;
    localparam int SPAN_W       = TURN_BITS + 1;
    localparam int IDX_W        = 11;
    localparam int CNT_W        = 11;
    localparam int COORD_W      = 22;
    localparam int CFG_W        = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 34;
    localparam int DEN1_W       = IDX_W + 1;
    localparam int Q1_W         = ANG_W;
    localparam int DEN2_W       = 32;
    localparam int Q2_W         = COORD_W;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [30:0]          Q30_ONE     = 31'h40000000;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_START  = 2'd1;
    localparam logic [1:0] REG_END    = 2'd2;
    localparam logic [1:0] REG_COUNT  = 2'd3;

    localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

endpackage

@@ rtl/psv_div_cell.sv @@
// One restoring-division cell: a single quotient bit per cycle while en is high.
// Uses no package items; chained by the top level.
module psv_div_cell #(
    parameter int DW = 12,
    parameter int QW = 32
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] rem_i,
    input  logic [QW-1:0] nq_i,
    input  logic [DW-1:0] den_i,
    output logic [DW-1:0] rem_o,
    output logic [QW-1:0] nq_o,
    output logic [DW-1:0] den_o
);
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] nq_reg;
    logic [DW-1:0] den_reg;

    assign t    = {rem_i, nq_i[QW-1]};
    assign ge   = t >= {1'b0, den_i};
    assign diff = t - {1'b0, den_i};

    // take the next numerator bit from the top, shift the quotient bit in at the bottom
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= ge ? diff[DW-1:0] : t[DW-1:0];
            nq_reg  <= {nq_i[QW-2:0], ge};
            den_reg <= den_i;
        end
    end

    assign rem_o = rem_reg;
    assign nq_o  = nq_reg;
    assign den_o = den_reg;
endmodule

@@ rtl/psv_cordic_cell.sv @@
// One rotation step of the CORDIC, arithmetic right shifts, fixed step index.
// Depends on psv_pkg for the arctangent table and word width.
module psv_cordic_cell
    import psv_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [CW-1:0] x_i,
    input  logic signed [CW-1:0] y_i,
    input  logic signed [CW-1:0] z_i,
    output logic signed [CW-1:0] x_o,
    output logic signed [CW-1:0] y_o,
    output logic signed [CW-1:0] z_o
);
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] at;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] z_reg;

    assign xs = x_i >>> STEP;
    assign ys = y_i >>> STEP;
    assign at = signed'({{(CW-32){1'b0}}, ATAN_TAB[STEP]});

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!z_i[CW-1]) begin
                x_reg <= x_i - ys;
                y_reg <= y_i + xs;
                z_reg <= z_i - at;
            end else begin
                x_reg <= x_i + ys;
                y_reg <= y_i - xs;
                z_reg <= z_i + at;
            end
        end
    end

    assign x_o = x_reg;
    assign y_o = y_reg;
    assign z_o = z_reg;
endmodule

@@ rtl/pie_slice_vertex_generator_top.sv @@
// Pie-slice vertex generator top level: span and segment count, offset and half-step
// dividers, CORDIC rows, scaling divider and output skid. Depends on psv_pkg and both cells.
//
//  channel | ports        | content
//  input   | s_t*         | tdata[10:0] vertex_index
//  result  | m_t*         | tdata x_coord, y_coord, vertex_total; tuser in_range
//  config  | cfg_*        | index 0..3: radius, start, end, point count
//
// One item per cycle while the skid stage is empty: 32 offset-divider cells, 30 CORDIC cells
// and 22 scaling-divider cells in series, plus nine setup, finishing and output stages.
// aresetn (synchronous) empties the pipeline and loads the register defaults.
// A full skid stage freezes the whole pipeline; s_tready is that stage's empty flag.
module pie_slice_vertex_generator_top
    import psv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // [10:0] vertex_index
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [55:0]      m_tdata,   // [21:0] x_coord, [43:22] y_coord, [54:44] vertex_total
    output logic             m_tuser,   // in_range
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  n;
        logic [SPAN_W-1:0] span;
    } side1_t;

    typedef struct packed {
        logic             neg;
        logic             negh;
        logic             ok;
        logic             outer;
        logic             zero;
        logic [IDX_W-1:0] total;
    } side2_t;

    typedef struct packed {
        logic             sx;
        logic             sy;
        logic             ok;
        logic             zero;
        logic [IDX_W-1:0] total;
    } side3_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               ok;
        logic [IDX_W-1:0]   total;
    } res_t;

    localparam logic [SPAN_W-1:0]     TURN    = SPAN_W'(2**TURN_BITS);
    localparam int                    PROD_W  = CNT_W + SPAN_W;
    localparam logic signed [CW-1:0]  QUARTER = 34'sh040000000;
    localparam logic signed [CW-1:0]  HALF_T  = 34'sh080000000;

    logic [RADIUS_BITS-1:0] radius_reg;
    logic [ANG_W-1:0]       start_reg;
    logic [ANG_W-1:0]       end_reg;
    logic [CNT_W-1:0]       count_reg;

    logic en;
    logic skid_valid_reg;
    res_t skid_reg;
    res_t m_reg;
    logic m_valid_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_BITS'(1000);
            start_reg  <= '0;
            end_reg    <= ANG_W'(16384);
            count_reg  <= CNT_W'(64);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_data[RADIUS_BITS-1:0];
                REG_START:  start_reg  <= cfg_data;
                REG_END:    end_reg    <= cfg_data;
                REG_COUNT:  count_reg  <= cfg_data[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // stage A: span and clamped count
    logic signed [ANG_W:0] a1;
    logic signed [ANG_W:0] a2;
    logic [ANG_W:0]        d_dn;
    logic [ANG_W:0]        d_up;
    logic [SPAN_W-1:0]     span_a;
    logic [CNT_W-1:0]      cnt_a;
    logic                  a_valid_reg;
    logic [IDX_W-1:0]      a_idx_reg;
    logic [SPAN_W-1:0]     a_span_reg;
    logic [CNT_W-1:0]      a_cnt_reg;

    assign a1   = signed'({start_reg[ANG_W-1], start_reg});
    assign a2   = signed'({end_reg[ANG_W-1], end_reg});
    assign d_dn = a1 - a2;
    assign d_up = a2 - a1;

    always_comb begin
        if (a2 < a1) begin
            if (d_dn[TURN_BITS-1:0] == '0) begin
                span_a = TURN;
            end else begin
                span_a = TURN - {1'b0, d_dn[TURN_BITS-1:0]};
            end
        end else if (d_up > (ANG_W+1)'(TURN)) begin
            span_a = TURN;
        end else begin
            span_a = d_up[SPAN_W-1:0];
        end
        if (count_reg < CNT_W'(8)) begin
            cnt_a = CNT_W'(8);
        end else if (count_reg > CNT_W'(MAX_POINTS)) begin
            cnt_a = CNT_W'(MAX_POINTS);
        end else begin
            cnt_a = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_idx_reg  <= s_tdata[IDX_W-1:0];
            a_span_reg <= span_a;
            a_cnt_reg  <= cnt_a;
        end
    end

    // stage B: segment count
    logic [PROD_W-1:0]       prod_b;
    logic [PROD_W-TURN_BITS-1:0] n_raw;
    logic                    b_valid_reg;
    side1_t                  b_reg;

    assign prod_b = ({{SPAN_W{1'b0}}, a_cnt_reg} * {{CNT_W{1'b0}}, a_span_reg})
                    + PROD_W'(2**(TURN_BITS-1));
    assign n_raw  = prod_b[PROD_W-1:TURN_BITS];

    always_ff @(posedge aclk) begin
        if (en) begin
            b_reg.idx  <= a_idx_reg;
            b_reg.span <= a_span_reg;
            b_reg.n    <= (n_raw < (PROD_W-TURN_BITS)'(2)) ? IDX_W'(2) : n_raw[IDX_W-1:0];
        end
    end

    // stage C: divider numerators
    localparam int OS_W  = DEN1_W + SPAN_W;
    localparam int OFF_W = OS_W + PH_SHIFT + 1;
    logic [DEN1_W-1:0]     odd_c;
    logic [OS_W-1:0]       odd_span;
    logic [OFF_W-1:0]      off_num;
    logic [SPAN_W+PH_SHIFT-1:0] half_num;
    logic                  c_valid_reg;
    side1_t                c_side_reg;
    logic [DEN1_W-1:0]     c_rem_off_reg;
    logic [Q1_W-1:0]       c_nq_off_reg;
    logic [DEN1_W-1:0]     c_rem_half_reg;
    logic [Q1_W-1:0]       c_nq_half_reg;
    logic [DEN1_W-1:0]     c_den_reg;

    assign odd_c    = {b_reg.idx, 1'b1};
    assign odd_span = {{SPAN_W{1'b0}}, odd_c} * {{DEN1_W{1'b0}}, b_reg.span};
    assign off_num  = {1'b0, odd_span, {PH_SHIFT{1'b0}}} + OFF_W'(b_reg.n);
    assign half_num = {b_reg.span, {PH_SHIFT{1'b0}}} + (SPAN_W+PH_SHIFT)'(b_reg.n);

    always_ff @(posedge aclk) begin
        if (en) begin
            c_side_reg     <= b_reg;
            c_rem_off_reg  <= off_num[Q1_W +: DEN1_W];
            c_nq_off_reg   <= off_num[Q1_W-1:0];
            c_rem_half_reg <= DEN1_W'(half_num[SPAN_W+PH_SHIFT-1:Q1_W]);
            c_nq_half_reg  <= half_num[Q1_W-1:0];
            c_den_reg      <= {b_reg.n, 1'b0};
        end
    end

    // offset and half-step dividers
    logic [DEN1_W-1:0] o_rem [0:Q1_W];
    logic [Q1_W-1:0]   o_nq  [0:Q1_W];
    logic [DEN1_W-1:0] o_den [0:Q1_W];
    logic [DEN1_W-1:0] h_rem [0:Q1_W];
    logic [Q1_W-1:0]   h_nq  [0:Q1_W];
    logic [DEN1_W-1:0] h_den [0:Q1_W];
    logic              v1_reg [1:Q1_W];
    side1_t            sd1_reg [1:Q1_W];

    assign o_rem[0] = c_rem_off_reg;
    assign o_nq[0]  = c_nq_off_reg;
    assign o_den[0] = c_den_reg;
    assign h_rem[0] = c_rem_half_reg;
    assign h_nq[0]  = c_nq_half_reg;
    assign h_den[0] = c_den_reg;

    for (genvar i = 0; i < Q1_W; i++) begin : g_div1
        psv_div_cell #(.DW(DEN1_W), .QW(Q1_W)) u_off (
            .aclk(aclk), .en(en),
            .rem_i(o_rem[i]), .nq_i(o_nq[i]), .den_i(o_den[i]),
            .rem_o(o_rem[i+1]), .nq_o(o_nq[i+1]), .den_o(o_den[i+1])
        );
        psv_div_cell #(.DW(DEN1_W), .QW(Q1_W)) u_half (
            .aclk(aclk), .en(en),
            .rem_i(h_rem[i]), .nq_i(h_nq[i]), .den_i(h_den[i]),
            .rem_o(h_rem[i+1]), .nq_o(h_nq[i+1]), .den_o(h_den[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd1_reg[1] <= c_side_reg;
            for (int i = 2; i <= Q1_W; i++) begin
                sd1_reg[i] <= sd1_reg[i-1];
            end
        end
    end

    // stage E: vertex angle and kind
    side1_t            s1e;
    logic [ANG_W-1:0]  ph1;
    logic [ANG_W-1:0]  span_ph;
    logic [DEN1_W-1:0] idx_e;
    logic [DEN1_W-1:0] n_e;
    logic              outer_e;
    logic              end_e;
    logic              start_e;
    logic              e_valid_reg;
    logic [ANG_W-1:0]  e_ang_reg;
    logic [ANG_W-1:0]  e_half_reg;
    side2_t            e_side_reg;

    assign s1e     = sd1_reg[Q1_W];
    assign ph1     = {start_reg[TURN_BITS-1:0], {PH_SHIFT{1'b0}}};
    assign span_ph = {s1e.span[TURN_BITS-1:0], {PH_SHIFT{1'b0}}};
    assign idx_e   = {1'b0, s1e.idx};
    assign n_e     = {1'b0, s1e.n};
    assign outer_e = idx_e < n_e;
    assign end_e   = idx_e == n_e;
    assign start_e = idx_e == n_e + DEN1_W'(2);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (outer_e) begin
                e_ang_reg <= ph1 + o_nq[Q1_W];
            end else if (end_e) begin
                e_ang_reg <= ph1 + span_ph;
            end else begin
                e_ang_reg <= ph1;
            end
            e_half_reg       <= h_nq[Q1_W];
            e_side_reg.neg   <= 1'b0;
            e_side_reg.negh  <= 1'b0;
            e_side_reg.ok    <= idx_e < n_e + DEN1_W'(3);
            e_side_reg.outer <= outer_e;
            e_side_reg.zero  <= !(outer_e || end_e || start_e);
            e_side_reg.total <= s1e.n + IDX_W'(3);
        end
    end

    // stage F: fold into a quarter turn either side of zero
    logic signed [CW-1:0] z_e;
    logic signed [CW-1:0] zh_e;
    logic                 f_valid_reg;
    logic signed [CW-1:0] f_z_reg;
    logic signed [CW-1:0] f_zh_reg;
    side2_t               f_side_reg;

    assign z_e  = signed'({{(CW-ANG_W){e_ang_reg[ANG_W-1]}}, e_ang_reg});
    assign zh_e = signed'({{(CW-ANG_W){e_half_reg[ANG_W-1]}}, e_half_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            f_side_reg.ok    <= e_side_reg.ok;
            f_side_reg.outer <= e_side_reg.outer;
            f_side_reg.zero  <= e_side_reg.zero;
            f_side_reg.total <= e_side_reg.total;
            if (z_e > QUARTER) begin
                f_z_reg         <= z_e - HALF_T;
                f_side_reg.neg  <= 1'b1;
            end else if (z_e < -QUARTER) begin
                f_z_reg         <= z_e + HALF_T;
                f_side_reg.neg  <= 1'b1;
            end else begin
                f_z_reg         <= z_e;
                f_side_reg.neg  <= 1'b0;
            end
            if (zh_e > QUARTER) begin
                f_zh_reg        <= zh_e - HALF_T;
                f_side_reg.negh <= 1'b1;
            end else if (zh_e < -QUARTER) begin
                f_zh_reg        <= zh_e + HALF_T;
                f_side_reg.negh <= 1'b1;
            end else begin
                f_zh_reg        <= zh_e;
                f_side_reg.negh <= 1'b0;
            end
        end
    end

    // CORDIC rows: vertex angle and half step
    logic signed [CW-1:0] cx  [0:CORDIC_STEPS];
    logic signed [CW-1:0] cy  [0:CORDIC_STEPS];
    logic signed [CW-1:0] cz  [0:CORDIC_STEPS];
    logic signed [CW-1:0] hx  [0:CORDIC_STEPS];
    logic signed [CW-1:0] hy  [0:CORDIC_STEPS];
    logic signed [CW-1:0] hz  [0:CORDIC_STEPS];
    logic                 v2_reg  [1:CORDIC_STEPS];
    side2_t               sd2_reg [1:CORDIC_STEPS];

    assign cx[0] = CORDIC_GAIN;
    assign cy[0] = '0;
    assign cz[0] = f_z_reg;
    assign hx[0] = CORDIC_GAIN;
    assign hy[0] = '0;
    assign hz[0] = f_zh_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        psv_cordic_cell #(.STEP(k)) u_main (
            .aclk(aclk), .en(en),
            .x_i(cx[k]), .y_i(cy[k]), .z_i(cz[k]),
            .x_o(cx[k+1]), .y_o(cy[k+1]), .z_o(cz[k+1])
        );
        psv_cordic_cell #(.STEP(k)) u_half (
            .aclk(aclk), .en(en),
            .x_i(hx[k]), .y_i(hy[k]), .z_i(hz[k]),
            .x_o(hx[k+1]), .y_o(hy[k+1]), .z_o(hz[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd2_reg[1] <= f_side_reg;
            for (int i = 2; i <= CORDIC_STEPS; i++) begin
                sd2_reg[i] <= sd2_reg[i-1];
            end
        end
    end

    // stage G: signs, divisor choice, radius products
    side2_t               s2g;
    logic signed [CW-1:0] c_g;
    logic signed [CW-1:0] s_g;
    logic signed [CW-1:0] ch_g;
    logic signed [31:0]   c32;
    logic signed [31:0]   s32;
    logic [30:0]          dv_g;
    logic signed [52:0]   px_g;
    logic signed [52:0]   py_g;
    logic                 g_valid_reg;
    logic signed [52:0]   g_px_reg;
    logic signed [52:0]   g_py_reg;
    logic [30:0]          g_dv_reg;
    side2_t               g_side_reg;

    assign s2g  = sd2_reg[CORDIC_STEPS];
    assign c_g  = s2g.neg  ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
    assign s_g  = s2g.neg  ? -cy[CORDIC_STEPS] : cy[CORDIC_STEPS];
    assign ch_g = s2g.negh ? -hx[CORDIC_STEPS] : hx[CORDIC_STEPS];
    assign c32  = c_g[31:0];
    assign s32  = s_g[31:0];
    assign dv_g = (s2g.outer && ch_g > 0) ? ch_g[30:0] : Q30_ONE;
    assign px_g = $signed({1'b0, radius_reg}) * c32;
    assign py_g = $signed({1'b0, radius_reg}) * s32;

    always_ff @(posedge aclk) begin
        if (en) begin
            g_px_reg   <= px_g;
            g_py_reg   <= py_g;
            g_dv_reg   <= dv_g;
            g_side_reg <= s2g;
        end
    end

    // stage H: magnitudes and rounding offset
    logic [52:0]       mx_h;
    logic [52:0]       my_h;
    logic [53:0]       nx_h;
    logic [53:0]       ny_h;
    logic              h_valid_reg;
    logic [DEN2_W-1:0] h_remx_reg;
    logic [Q2_W-1:0]   h_nqx_reg;
    logic [DEN2_W-1:0] h_remy_reg;
    logic [Q2_W-1:0]   h_nqy_reg;
    logic [DEN2_W-1:0] h_den_reg;
    side3_t            h_side_reg;

    assign mx_h = g_px_reg[52] ? 53'(-g_px_reg) : 53'(g_px_reg);
    assign my_h = g_py_reg[52] ? 53'(-g_py_reg) : 53'(g_py_reg);
    assign nx_h = {mx_h, 1'b0} + 54'(g_dv_reg);
    assign ny_h = {my_h, 1'b0} + 54'(g_dv_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            h_remx_reg       <= nx_h[53:Q2_W];
            h_nqx_reg        <= nx_h[Q2_W-1:0];
            h_remy_reg       <= ny_h[53:Q2_W];
            h_nqy_reg        <= ny_h[Q2_W-1:0];
            h_den_reg        <= {g_dv_reg, 1'b0};
            h_side_reg.sx    <= g_px_reg[52];
            h_side_reg.sy    <= g_py_reg[52];
            h_side_reg.ok    <= g_side_reg.ok;
            h_side_reg.zero  <= g_side_reg.zero;
            h_side_reg.total <= g_side_reg.total;
        end
    end

    // scaling dividers
    logic [DEN2_W-1:0] xr  [0:Q2_W];
    logic [Q2_W-1:0]   xq  [0:Q2_W];
    logic [DEN2_W-1:0] xd  [0:Q2_W];
    logic [DEN2_W-1:0] yr  [0:Q2_W];
    logic [Q2_W-1:0]   yq  [0:Q2_W];
    logic [DEN2_W-1:0] yd  [0:Q2_W];
    logic              v3_reg  [1:Q2_W];
    side3_t            sd3_reg [1:Q2_W];

    assign xr[0] = h_remx_reg;
    assign xq[0] = h_nqx_reg;
    assign xd[0] = h_den_reg;
    assign yr[0] = h_remy_reg;
    assign yq[0] = h_nqy_reg;
    assign yd[0] = h_den_reg;

    for (genvar i = 0; i < Q2_W; i++) begin : g_div2
        psv_div_cell #(.DW(DEN2_W), .QW(Q2_W)) u_x (
            .aclk(aclk), .en(en),
            .rem_i(xr[i]), .nq_i(xq[i]), .den_i(xd[i]),
            .rem_o(xr[i+1]), .nq_o(xq[i+1]), .den_o(xd[i+1])
        );
        psv_div_cell #(.DW(DEN2_W), .QW(Q2_W)) u_y (
            .aclk(aclk), .en(en),
            .rem_i(yr[i]), .nq_i(yq[i]), .den_i(yd[i]),
            .rem_o(yr[i+1]), .nq_o(yq[i+1]), .den_o(yd[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd3_reg[1] <= h_side_reg;
            for (int i = 2; i <= Q2_W; i++) begin
                sd3_reg[i] <= sd3_reg[i-1];
            end
        end
    end

    // stage I: apply sign, blank the origin and out-of-range items
    side3_t          s3i;
    logic            i_valid_reg;
    res_t            i_reg;

    assign s3i = sd3_reg[Q2_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (s3i.zero) begin
                i_reg.x <= '0;
                i_reg.y <= '0;
            end else begin
                i_reg.x <= s3i.sx ? -xq[Q2_W] : xq[Q2_W];
                i_reg.y <= s3i.sy ? -yq[Q2_W] : yq[Q2_W];
            end
            i_reg.ok    <= s3i.ok;
            i_reg.total <= s3i.total;
        end
    end

    // valid flags along the whole pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
            for (int i = 1; i <= Q1_W; i++) v1_reg[i] <= 1'b0;
            for (int i = 1; i <= CORDIC_STEPS; i++) v2_reg[i] <= 1'b0;
            for (int i = 1; i <= Q2_W; i++) v3_reg[i] <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            v1_reg[1]   <= c_valid_reg;
            for (int i = 2; i <= Q1_W; i++) v1_reg[i] <= v1_reg[i-1];
            e_valid_reg <= v1_reg[Q1_W];
            f_valid_reg <= e_valid_reg;
            v2_reg[1]   <= f_valid_reg;
            for (int i = 2; i <= CORDIC_STEPS; i++) v2_reg[i] <= v2_reg[i-1];
            g_valid_reg <= v2_reg[CORDIC_STEPS];
            h_valid_reg <= g_valid_reg;
            v3_reg[1]   <= h_valid_reg;
            for (int i = 2; i <= Q2_W; i++) v3_reg[i] <= v3_reg[i-1];
            i_valid_reg <= v3_reg[Q2_W];
        end
    end

    // output register and skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                m_reg          <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (i_valid_reg) begin
            if (!m_valid_reg || m_tready) begin
                m_reg       <= i_reg;
                m_valid_reg <= 1'b1;
            end else begin
                // hold the item aside; the pipeline freezes next cycle
                skid_reg       <= i_reg;
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_reg.total, m_reg.y, m_reg.x};
    assign m_tuser  = m_reg.ok;
endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Regression bench for the pie-slice vertex generator: vertex requests in,
// coordinates out, checked against a local fixed-point predictor. Uses psv_pkg.
module tb;
    import psv_pkg::*;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata = '0;    // [10:0] vertex_index
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [55:0]      m_tdata;         // [21:0] x, [43:22] y, [54:44] vertex_total
    logic             m_tuser;         // in_range
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_index = REG_RADIUS;
    logic [CFG_W-1:0] cfg_data = '0;

    pie_slice_vertex_generator_top DUT (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               in_range;
        logic [IDX_W-1:0]   total;
    } vertex_t;

    localparam int LATENCY = 93;
    localparam int STALL_LIMIT = 2000;

    logic [19:0] radius_q;
    logic [31:0] start_q, end_q;
    logic [10:0] count_q;
    vertex_t     vertex_q[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          no_idle = 0;

    // 30-step rotation, cos/sin in Q30, arithmetic shifts floor
    function automatic void rotate(input logic [31:0] phase, output longint c,
                                   output longint s);
        longint z, x, y, nx;
        bit neg;
        z = phase;
        x = CORDIC_GAIN;
        y = 0;
        neg = 0;
        if (z >= 64'sh80000000) z -= 64'sh100000000;
        if (z > 64'sh40000000) begin
            z -= 64'sh80000000;
            neg = 1;
        end else if (z < -64'sh40000000) begin
            z += 64'sh80000000;
            neg = 1;
        end
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            if (z >= 0) begin
                nx = x - (y >>> k);
                y = y + (x >>> k);
                z -= longint'(ATAN_TAB[k]);
            end else begin
                nx = x + (y >>> k);
                y = y - (x >>> k);
                z += longint'(ATAN_TAB[k]);
            end
            x = nx;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic longint div_half_away(longint num, longint den);
        longint m, q;
        m = num < 0 ? -num : num;
        q = (2 * m + den) / (2 * den);
        return num < 0 ? -q : q;
    endfunction

    function automatic vertex_t vertex_of(logic [10:0] idx);
        longint turn, a1, a2, r, cnt, span, n, off, half, x, y, c, s, ch, sh;
        logic [31:0] ph1;
        vertex_t v;
        turn = 1 << TURN_BITS;
        a1 = longint'(signed'(start_q));
        a2 = longint'(signed'(end_q));
        r = radius_q;
        ph1 = start_q << PH_SHIFT;
        x = 0;
        y = 0;
        if (a2 < a1) span = turn - ((a1 - a2) % turn);
        else begin
            span = a2 - a1;
            if (span > turn) span = turn;
        end
        cnt = count_q;
        if (cnt < 8) cnt = 8;
        if (cnt > MAX_POINTS) cnt = MAX_POINTS;
        n = (cnt * span + turn / 2) >> TURN_BITS;
        if (n < 2) n = 2;
        v.in_range = idx < n + 3;
        if (v.in_range) begin
            if (idx < n) begin
                off = (((2 * idx + 1) * span << PH_SHIFT) + n) / (2 * n);
                half = ((span << PH_SHIFT) + n) / (2 * n);
                rotate(ph1 + 32'(off), c, s);
                rotate(32'(half), ch, sh);
                if (ch <= 0) ch = Q30_ONE;
                x = div_half_away(r * c, ch);
                y = div_half_away(r * s, ch);
            end else if (idx == n || idx == n + 2) begin
                rotate(idx == n ? ph1 + 32'(span << PH_SHIFT) : ph1, c, s);
                x = div_half_away(r * c, Q30_ONE);
                y = div_half_away(r * s, Q30_ONE);
            end
        end
        v.x = x[COORD_W-1:0];
        v.y = y[COORD_W-1:0];
        v.total = 11'(n + 3);
        return v;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            REG_RADIUS: radius_q = val[19:0];
            REG_START:  start_q = val;
            REG_END:    end_q = val;
            default:    count_q = val[10:0];
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        wait (vertex_q.size() == 0);
        repeat (LATENCY + 8) @(negedge aclk);
    endtask

    // send one vertex request; expected value may be preset by the table
    // entered and left at a falling edge, tvalid stays high for a following item
    task automatic request(input logic [10:0] idx, input bit fixed, input vertex_t want);
        vertex_t exp_v;
        while (!no_idle && $urandom_range(99) < 21) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        exp_v = fixed ? want : vertex_of(idx);
        s_tvalid = 1'b1;
        s_tdata = {5'd0, idx};
        vertex_q = {vertex_q, exp_v};
        // s_tready only moves at the rising edge, so its value here holds for the next one
        while (!s_tready) @(negedge aclk);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            vertex_t got, want;
            got = '{m_tdata[21:0], m_tdata[43:22], m_tuser, m_tdata[54:44]};
            if (vertex_q.size() == 0) begin
                $error("unexpected vertex %h", got);
                errors++;
            end else begin
                want = vertex_q.pop_front();
                if (got.x !== want.x) begin
                    $error("x_coord exp %h got %h", want.x, got.x); errors++;
                end
                if (got.y !== want.y) begin
                    $error("y_coord exp %h got %h", want.y, got.y); errors++;
                end
                if (got.in_range !== want.in_range) begin
                    $error("in_range exp %b got %b", want.in_range, got.in_range); errors++;
                end
                if (got.total !== want.total) begin
                    $error("vertex_total exp %0d got %0d", want.total, got.total); errors++;
                end
            end
        end
    end

    always @(negedge aclk) m_tready <= no_idle || ($urandom_range(99) >= 21);

    // watchdog on accepted items in either direction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("pie_slice_vertex_generator_top regression: fail");
            $finish;
        end
    end

    vertex_t zero_v;
    vertex_t probe;
    logic [10:0] dir_idx[0:13] = '{0, 1, 15, 16, 17, 18, 19, 20, 1026, 2047, 1024, 5, 3, 8};

    initial begin
        radius_q = 1000; start_q = 0; end_q = 16384; count_q = 64;
        repeat (4) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;

        // reset setting: quarter turn at 64 points gives 16 segments, 19 vertices
        for (int i = 0; i < 14; i++) begin
            zero_v = '{0, 0, 1'b0, 11'd19};
            if (dir_idx[i] == 18) zero_v = '{22'd1000, 22'd0, 1'b1, 11'd19};
            if (dir_idx[i] == 17) zero_v = '{22'd0, 22'd0, 1'b1, 11'd19};
            request(dir_idx[i], dir_idx[i] >= 17, zero_v);
        end
        drain();
        // extremes: full radius, full turn, most points; then end equal to start
        write_reg(REG_RADIUS, 32'hFFFFF);
        write_reg(REG_START, 32'h80000000);
        write_reg(REG_END, 32'h7FFFFFFF);
        write_reg(REG_COUNT, 11'd1024);
        for (int i = 0; i < 6; i++) request(i == 5 ? 11'd1026 : 11'(i * 200), 0, zero_v);
        drain();
        write_reg(REG_END, 32'h80000000);
        write_reg(REG_COUNT, 11'd0);
        for (int i = 0; i < 6; i++) request(11'(i), 0, zero_v);
        drain();

        for (int phase = 0; phase < 13; phase++) begin
            no_idle = (phase == 4);
            write_reg(REG_RADIUS, $urandom_range(3) == 0 ? 32'hFFFFF : $urandom_range(20'hFFFFF));
            write_reg(REG_START, $urandom_range(1) ? $urandom : $urandom_range(131071) - 65536);
            case ($urandom_range(3))
                0: write_reg(REG_END, start_q - $urandom_range(200000));
                1: write_reg(REG_END, $urandom);
                default: write_reg(REG_END, start_q + $urandom_range(80000));
            endcase
            write_reg(REG_COUNT, $urandom_range(3) == 0 ? $urandom_range(2047)
                                                         : $urandom_range(1024));
            probe = vertex_of(11'd0);
            for (int i = 0; i < 100; i++)
                request($urandom_range(9) == 0 ? 11'($urandom)
                                               : 11'($urandom_range(probe.total)), 0, zero_v);
            drain();
        end
        no_idle = 0;

        if (errors == 0) $display("pie_slice_vertex_generator_top regression: pass");
        else $display("pie_slice_vertex_generator_top regression: fail");
        $finish;
    end
endmodule
